@@ src/tmf_pkg.sv @@
// ----------------------------------------------------------------------------
// Typed message FIFO package
// Shared sizes, command and status codes, and slot arithmetic for the
// typed message FIFO.
// ----------------------------------------------------------------------------
package tmf_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int PTR_W       = ADDR_W + 1;

    localparam int TYPE_W = 8;
    localparam int BADDR_W = 32;
    localparam int LEN_W  = 16;
    localparam int DESC_W = TYPE_W + BADDR_W + LEN_W;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_POP  = 2'd1;
    localparam logic [1:0] MODE_GET  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        K_PUSH = 2'd0,
        K_POP  = 2'd1,
        K_GET  = 2'd2,
        K_NOP  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [TYPE_W-1:0]   msg_type;
        logic [BADDR_W-1:0]  buf_addr;
        logic [LEN_W-1:0]    msg_len;
    } t_cmd;

    function automatic logic [ADDR_W-1:0] slot_of(input logic [PTR_W-1:0] rp,
                                                  input logic [ADDR_W-1:0] off);
        return rp[ADDR_W-1:0] + off;
    endfunction

endpackage

@@ src/typed_message_fifo.sv @@
// ----------------------------------------------------------------------------
// Typed message FIFO
// Ring queue of message descriptors with push, pop and get-by-type.
// ----------------------------------------------------------------------------
// A command transaction is accepted when start is high and busy is low. The
// mode selects push, pop of the head, or removal of the oldest descriptor of
// the given type; mode 3 is a no-op that still returns a result. Commands
// enter a two-entry queue, so a new transaction can be accepted while the
// previous one is still being executed; busy rises only when that queue is
// full. Every command gives exactly one result, shown for a single cycle
// with o_strobe high. The receiver cannot stall, so results are never held.
// Push, no-op, and a pop or get on an empty queue are answered directly from
// the idle state; any other pop first reads the head from the descriptor memory.
// Get-by-type scans one entry per cycle and then moves each older entry
// up one slot per cycle through the descriptor memory. Reset empties the
// queue and the command queue; the memory content is not cleared.
// ----------------------------------------------------------------------------
module typed_message_fifo
    import tmf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_mode,
    input  logic [TYPE_W-1:0]   i_msg_type,
    input  logic [BADDR_W-1:0]  i_buf_addr,
    input  logic [LEN_W-1:0]    i_msg_len,
    output logic                o_strobe,
    output logic [1:0]          o_status,
    output logic [TYPE_W-1:0]   o_out_type,
    output logic [BADDR_W-1:0]  o_out_addr,
    output logic [LEN_W-1:0]    o_out_len
);

    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_q_pop;

    tmf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_mode     (i_mode),
        .i_msg_type (i_msg_type),
        .i_buf_addr (i_buf_addr),
        .i_msg_len  (i_msg_len),
        .o_q_valid  (w_q_valid),
        .o_q_cmd    (w_q_cmd),
        .i_q_pop    (w_q_pop)
    );

    tmf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_cmd    (w_q_cmd),
        .o_q_pop    (w_q_pop),
        .o_strobe   (o_strobe),
        .o_status   (o_status),
        .o_out_type (o_out_type),
        .o_out_addr (o_out_addr),
        .o_out_len  (o_out_len)
    );

endmodule

@@ src/tmf_front.sv @@
// ----------------------------------------------------------------------------
// Typed message FIFO front end
// Accepts command transactions, decodes the mode into a command kind and
// holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module tmf_front
    import tmf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_mode,
    input  logic [TYPE_W-1:0]   i_msg_type,
    input  logic [BADDR_W-1:0]  i_buf_addr,
    input  logic [LEN_W-1:0]    i_msg_len,
    output logic                o_q_valid,
    output t_cmd                o_q_cmd,
    input  logic                i_q_pop
);

    t_cmd                 r_q [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]   r_wr;
    logic [CMDQ_AW-1:0]   r_rd;
    logic [CMDQ_AW:0]     r_cnt;
    logic                 w_push;
    t_cmd                 w_cmd;

    always_comb begin
        w_cmd.msg_type = i_msg_type;
        w_cmd.buf_addr = i_buf_addr;
        w_cmd.msg_len  = i_msg_len;
        case (i_mode)
            MODE_PUSH: w_cmd.kind = K_PUSH;
            MODE_POP:  w_cmd.kind = K_POP;
            MODE_GET:  w_cmd.kind = K_GET;
            default:   w_cmd.kind = K_NOP;
        endcase
    end

    assign busy      = (r_cnt == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign w_push    = start && !busy;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_cmd   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !i_q_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && i_q_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ src/tmf_back.sv @@
// ----------------------------------------------------------------------------
// Typed message FIFO back end
// Executes push, pop, get-by-type and no-op commands against the descriptor
// memory and registers one result per command.
// ----------------------------------------------------------------------------
module tmf_back
    import tmf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_cmd                i_q_cmd,
    output logic                o_q_pop,
    output logic                o_strobe,
    output logic [1:0]          o_status,
    output logic [TYPE_W-1:0]   o_out_type,
    output logic [BADDR_W-1:0]  o_out_addr,
    output logic [LEN_W-1:0]    o_out_len
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_POP   = 4'b0010,
        S_SCAN  = 4'b0100,
        S_SHIFT = 4'b1000
    } t_state;

    logic [DESC_W-1:0]   r_mem [QUEUE_DEPTH];
    logic [DESC_W-1:0]   r_rdata;

    t_state              r_state, n_state;
    logic [PTR_W-1:0]    r_rp, n_rp;
    logic [PTR_W-1:0]    r_wp, n_wp;
    logic [ADDR_W-1:0]   r_k, n_k;
    logic [ADDR_W-1:0]   r_j, n_j;
    logic [TYPE_W-1:0]   r_type, n_type;
    logic [DESC_W-1:0]   r_hit, n_hit;
    logic                r_strobe, n_strobe;
    t_status             r_status, n_status;
    logic [DESC_W-1:0]   r_odesc, n_odesc;

    logic [PTR_W-1:0]    w_fill;
    logic [PTR_W-1:0]    w_used;
    logic                w_full;
    logic                w_match;
    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic [DESC_W-1:0]   w_wdata;
    logic [ADDR_W-1:0]   w_raddr;

    assign w_fill  = r_wp - r_rp;
    assign w_full  = (w_fill >= PTR_W'(QUEUE_DEPTH));
    assign w_used  = (w_fill > PTR_W'(QUEUE_DEPTH)) ? PTR_W'(QUEUE_DEPTH) : w_fill;
    assign w_match = (r_rdata[DESC_W-1 -: TYPE_W] == r_type);

    always_comb begin
        n_state  = r_state;
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_k      = r_k;
        n_j      = r_j;
        n_type   = r_type;
        n_hit    = r_hit;
        n_strobe = 1'b0;
        n_status = r_status;
        n_odesc  = r_odesc;
        o_q_pop  = 1'b0;
        w_we     = 1'b0;
        w_waddr  = r_wp[ADDR_W-1:0];
        w_wdata  = {i_q_cmd.msg_type, i_q_cmd.buf_addr, i_q_cmd.msg_len};
        w_raddr  = slot_of(r_rp, '0);

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_type  = i_q_cmd.msg_type;
                    case (i_q_cmd.kind)
                        K_PUSH: begin
                            n_strobe = 1'b1;
                            n_odesc  = '0;
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status = ST_OK;
                                w_we     = 1'b1;
                                n_wp     = r_wp + 1'b1;
                            end
                        end
                        K_POP: begin
                            if (w_used == '0) begin
                                n_strobe = 1'b1;
                                n_status = ST_NONE;
                                n_odesc  = '0;
                            end else begin
                                n_state = S_POP;
                            end
                        end
                        K_GET: begin
                            if (w_used == '0) begin
                                n_strobe = 1'b1;
                                n_status = ST_NONE;
                                n_odesc  = '0;
                            end else begin
                                n_k     = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_status = ST_OK;
                            n_odesc  = '0;
                        end
                    endcase
                end
            end
            S_POP: begin
                n_strobe = 1'b1;
                n_status = ST_OK;
                n_odesc  = r_rdata;
                n_rp     = r_rp + 1'b1;
                n_state  = S_IDLE;
            end
            S_SCAN: begin
                if (w_match) begin
                    if (r_k == '0) begin
                        n_strobe = 1'b1;
                        n_status = ST_OK;
                        n_odesc  = r_rdata;
                        n_rp     = r_rp + 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        w_raddr = slot_of(r_rp, r_k - 1'b1);
                        n_hit   = r_rdata;
                        n_j     = r_k;
                        n_state = S_SHIFT;
                    end
                end else begin
                    w_raddr = slot_of(r_rp, r_k + 1'b1);
                    if (({1'b0, r_k} + PTR_W'(1)) == w_used) begin
                        n_strobe = 1'b1;
                        n_status = ST_NONE;
                        n_odesc  = '0;
                        n_state  = S_IDLE;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            S_SHIFT: begin
                w_we    = 1'b1;
                w_waddr = slot_of(r_rp, r_j);
                w_wdata = r_rdata;
                w_raddr = slot_of(r_rp, r_j - ADDR_W'(2));
                if (r_j == ADDR_W'(1)) begin
                    n_strobe = 1'b1;
                    n_status = ST_OK;
                    n_odesc  = r_hit;
                    n_rp     = r_rp + 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_j = r_j - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rp     <= '0;
            r_wp     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rp     <= n_rp;
            r_wp     <= n_wp;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_j      <= n_j;
        r_type   <= n_type;
        r_hit    <= n_hit;
        r_status <= n_status;
        r_odesc  <= n_odesc;
    end

    assign o_strobe   = r_strobe;
    assign o_status   = r_status;
    assign o_out_type = r_odesc[DESC_W-1 -: TYPE_W];
    assign o_out_addr = r_odesc[LEN_W +: BADDR_W];
    assign o_out_len  = r_odesc[LEN_W-1:0];

endmodule
